// ===== hw/rtl/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared constants, command codes and status types of the allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int POOL_MAX_BYTES  = 65536;
  localparam int GRANULE_BYTES   = 8;
  localparam int SMALL_MAX_BYTES = 128;
  localparam int CLASS_COUNT     = 16;
  localparam int POOL_WORDS      = POOL_MAX_BYTES / 8;

  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 17;
  localparam int WORD_AW  = $clog2(POOL_WORDS);
  localparam int CLASS_W  = $clog2(CLASS_COUNT);
  localparam int STEP_W   = $clog2(POOL_WORDS) + 1;
  localparam int G_SHIFT  = $clog2(GRANULE_BYTES);
  localparam int RC_W     = 7;

  localparam logic [4:0] CMD_NONE      = 5'd0;
  localparam logic [4:0] CMD_LOAD      = 5'd1;
  localparam logic [4:0] CMD_FAIL      = 5'd2;
  localparam logic [4:0] CMD_EMIT      = 5'd3;
  localparam logic [4:0] CMD_HEAD_RD   = 5'd4;
  localparam logic [4:0] CMD_HEAD_POP  = 5'd5;
  localparam logic [4:0] CMD_RF_INIT   = 5'd6;
  localparam logic [4:0] CMD_RF_HDR    = 5'd7;
  localparam logic [4:0] CMD_RF_LINK   = 5'd8;
  localparam logic [4:0] CMD_RF_END    = 5'd9;
  localparam logic [4:0] CMD_LG_INIT   = 5'd10;
  localparam logic [4:0] CMD_LG_RDLINK = 5'd11;
  localparam logic [4:0] CMD_LG_RDHDR  = 5'd12;
  localparam logic [4:0] CMD_LG_UNLINK = 5'd13;
  localparam logic [4:0] CMD_LG_ADV    = 5'd14;
  localparam logic [4:0] CMD_CARVE     = 5'd15;
  localparam logic [4:0] CMD_FR_RD     = 5'd16;
  localparam logic [4:0] CMD_FR_Q      = 5'd17;
  localparam logic [4:0] CMD_FR_LINK   = 5'd18;

  typedef logic [4:0] cmd_t;

  typedef struct packed {
    logic is_free;
    logic addr_bad;
    logic zero_size;
    logic is_small;
    logic class_bad;
    logic head_empty;
    logic refill_fits;
    logic more;
    logic lg_live;
    logic lg_match;
    logic carve_fits;
    logic fr_bad;
    logic out_free;
  } status_t;

  localparam logic [2:0] REG_POOL_BYTES   = 3'd0;
  localparam logic [2:0] REG_REFILL_COUNT = 3'd4;

  function automatic logic link_ok(input logic [SIZE_W-1:0] v);
    link_ok = (v >= SIZE_W'(8)) && (v < SIZE_W'(POOL_MAX_BYTES)) &&
              (v[2:0] == 3'd0);
  endfunction

endpackage

// ===== hw/rtl/sfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer that steps the datapath through allocate and free operations.
// ----------------------------------------------------------------------------
module sfla_ctrl
  import sfla_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_FR_Q     = 4'd2;
  localparam logic [3:0] S_FR_LINK  = 4'd3;
  localparam logic [3:0] S_RF_HDR   = 4'd4;
  localparam logic [3:0] S_RF_LINK  = 4'd5;
  localparam logic [3:0] S_RF_END   = 4'd6;
  localparam logic [3:0] S_RD_HEAD  = 4'd7;
  localparam logic [3:0] S_POP      = 4'd8;
  localparam logic [3:0] S_LG_TEST  = 4'd9;
  localparam logic [3:0] S_LG_HDR   = 4'd10;
  localparam logic [3:0] S_LG_CMP   = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_free) begin
          if (status.addr_bad) begin
            cmd        = CMD_FAIL;
            state_next = S_EMIT;
          end else begin
            cmd        = CMD_FR_RD;
            state_next = S_FR_Q;
          end
        end else if (status.zero_size) begin
          cmd        = CMD_FAIL;
          state_next = S_EMIT;
        end else if (status.is_small) begin
          if (status.class_bad) begin
            cmd        = CMD_FAIL;
            state_next = S_EMIT;
          end else if (!status.head_empty) begin
            cmd        = CMD_HEAD_RD;
            state_next = S_POP;
          end else if (status.refill_fits) begin
            cmd        = CMD_RF_INIT;
            state_next = S_RF_HDR;
          end else begin
            cmd        = CMD_FAIL;
            state_next = S_EMIT;
          end
        end else begin
          cmd        = CMD_LG_INIT;
          state_next = S_LG_TEST;
        end
      end
      S_FR_Q: begin
        if (status.fr_bad) begin
          cmd        = CMD_FAIL;
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_FR_Q;
          state_next = S_FR_LINK;
        end
      end
      S_FR_LINK: begin
        cmd        = CMD_FR_LINK;
        state_next = S_EMIT;
      end
      S_RF_HDR: begin
        cmd        = CMD_RF_HDR;
        state_next = S_RF_LINK;
      end
      S_RF_LINK: begin
        cmd        = CMD_RF_LINK;
        state_next = status.more ? S_RF_HDR : S_RF_END;
      end
      S_RF_END: begin
        cmd        = CMD_RF_END;
        state_next = S_RD_HEAD;
      end
      S_RD_HEAD: begin
        cmd        = CMD_HEAD_RD;
        state_next = S_POP;
      end
      S_POP: begin
        cmd        = CMD_HEAD_POP;
        state_next = S_EMIT;
      end
      S_LG_TEST: begin
        if (status.lg_live) begin
          cmd        = CMD_LG_RDLINK;
          state_next = S_LG_HDR;
        end else if (status.carve_fits) begin
          cmd        = CMD_CARVE;
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_FAIL;
          state_next = S_EMIT;
        end
      end
      S_LG_HDR: begin
        cmd        = CMD_LG_RDHDR;
        state_next = S_LG_CMP;
      end
      S_LG_CMP: begin
        if (status.lg_match) begin
          cmd        = CMD_LG_UNLINK;
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_LG_ADV;
          state_next = S_LG_TEST;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/sfla_dp.sv =====
// ----------------------------------------------------------------------------
// sfla_dp
// Pool memory, list heads, carve pointer and result register.
// ----------------------------------------------------------------------------
module sfla_dp
  import sfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              in_opcode,
  input  logic [15:0]       in_size,
  input  logic [ADDR_W-1:0] in_free_addr,
  input  logic [SIZE_W-1:0] pool_end,
  input  logic [RC_W-1:0]   refill_count,
  input  logic              out_ready,
  output status_t           status,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_addr,
  output logic              out_ok
);

  logic [SIZE_W-1:0] mem [POOL_WORDS];

  logic              op_r;
  logic [15:0]       size_r;
  logic [ADDR_W-1:0] faddr;
  logic [SIZE_W-1:0] asz;
  logic [CLASS_W-1:0] hidx;
  logic [ADDR_W-1:0] cur, prev, nx;
  logic [SIZE_W-1:0] p;
  logic [RC_W-1:0]   cnt;
  logic [STEP_W-1:0] steps;
  logic              more;
  logic [SIZE_W-1:0] rdata;
  logic [ADDR_W-1:0] res_addr;
  logic              res_ok;
  logic [SIZE_W-1:0] carve;
  logic [ADDR_W-1:0] heads [CLASS_COUNT];
  logic [ADDR_W-1:0] large_head;

  logic [SIZE_W-1:0]  rnd;
  logic [SIZE_W:0]    real_sz;
  logic [SIZE_W-1:0]  room, room_p;
  logic [13:0]        cls;
  logic [ADDR_W-1:0]  head_cur;
  logic [ADDR_W-1:0]  nx_link;
  logic               fr_small;
  logic [SIZE_W-1:0]  q;
  logic [SIZE_W-1:0]  link_val;
  logic               re, we;
  logic [WORD_AW-1:0] raddr, waddr;
  logic [SIZE_W-1:0]  wdata;

  function automatic logic [CLASS_W-1:0] cls_in(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] a;
    a = (r == '0) ? SIZE_W'(GRANULE_BYTES) : r;
    cls_in = CLASS_W'((a >> G_SHIFT) - SIZE_W'(1));
  endfunction

  assign rnd = (SIZE_W'(in_size) + SIZE_W'(GRANULE_BYTES - 1)) &
               ~SIZE_W'(GRANULE_BYTES - 1);
  assign real_sz  = {1'b0, asz} + (SIZE_W+1)'(8);
  assign room     = (pool_end > carve) ? pool_end - carve : '0;
  assign room_p   = (pool_end > p) ? pool_end - p : '0;
  assign cls      = 14'(asz >> G_SHIFT) - 14'd1;
  assign head_cur = heads[hidx];
  assign nx_link  = link_ok(rdata) ? rdata[ADDR_W-1:0] : '0;
  assign fr_small = rdata <= SIZE_W'(SMALL_MAX_BYTES);
  assign q        = rdata >> G_SHIFT;
  assign link_val = more ? SIZE_W'(p + SIZE_W'(real_sz) + SIZE_W'(8)) : '0;

  always_comb begin
    status.is_free     = op_r;
    status.addr_bad    = !((faddr >= ADDR_W'(8)) && (faddr[2:0] == 3'd0) &&
                           ({1'b0, faddr} < SIZE_W'(POOL_MAX_BYTES)));
    status.zero_size   = (size_r == 16'd0);
    status.is_small    = (size_r <= 16'(SMALL_MAX_BYTES));
    status.class_bad   = (cls >= 14'(CLASS_COUNT));
    status.head_empty  = (head_cur == '0);
    status.refill_fits = (refill_count != '0) && ({1'b0, room} >= real_sz);
    status.more        = more;
    status.lg_live     = (cur != '0) && (steps < STEP_W'(POOL_WORDS));
    status.lg_match    = (rdata == asz);
    status.carve_fits  = ({1'b0, room} >= real_sz);
    status.fr_bad      = fr_small && ((q == '0) || (q > SIZE_W'(CLASS_COUNT)));
    status.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    re    = 1'b0;
    raddr = head_cur[ADDR_W-1:3];
    we    = 1'b0;
    waddr = p[ADDR_W-1:3];
    wdata = asz;
    case (cmd)
      CMD_HEAD_RD: begin
        re    = 1'b1;
        raddr = head_cur[ADDR_W-1:3];
      end
      CMD_LG_RDLINK: begin
        re    = 1'b1;
        raddr = cur[ADDR_W-1:3];
      end
      CMD_LG_RDHDR: begin
        re    = 1'b1;
        raddr = cur[ADDR_W-1:3] - WORD_AW'(1);
      end
      CMD_FR_RD: begin
        re    = 1'b1;
        raddr = faddr[ADDR_W-1:3] - WORD_AW'(1);
      end
      CMD_RF_HDR: begin
        we    = 1'b1;
        waddr = p[ADDR_W-1:3];
        wdata = asz;
      end
      CMD_RF_LINK: begin
        we    = 1'b1;
        waddr = p[ADDR_W-1:3] + WORD_AW'(1);
        wdata = link_val;
      end
      CMD_LG_UNLINK: begin
        we    = (prev != '0);
        waddr = prev[ADDR_W-1:3];
        wdata = SIZE_W'(nx);
      end
      CMD_CARVE: begin
        we    = 1'b1;
        waddr = carve[ADDR_W-1:3];
        wdata = asz;
      end
      CMD_FR_LINK: begin
        we    = 1'b1;
        waddr = faddr[ADDR_W-1:3];
        wdata = fr_small ? SIZE_W'(head_cur) : SIZE_W'(large_head);
      end
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r   <= in_opcode;
        size_r <= in_size;
        faddr  <= in_free_addr;
        asz    <= (rnd == '0) ? SIZE_W'(GRANULE_BYTES) : rnd;
      end
      CMD_FAIL: begin
        res_addr <= '0;
        res_ok   <= 1'b0;
      end
      CMD_RF_INIT: begin
        p   <= carve;
        cnt <= '0;
      end
      CMD_RF_HDR: begin
        more <= (({1'b0, cnt} + (RC_W+1)'(1)) < {1'b0, refill_count}) &&
                ({2'b0, room_p} >= {real_sz, 1'b0});
      end
      CMD_RF_LINK: begin
        p   <= p + SIZE_W'(real_sz);
        cnt <= cnt + RC_W'(1);
      end
      CMD_HEAD_POP: begin
        res_addr <= head_cur;
        res_ok   <= 1'b1;
      end
      CMD_LG_INIT: begin
        prev  <= '0;
        steps <= '0;
      end
      CMD_LG_RDHDR: nx <= nx_link;
      CMD_LG_ADV: begin
        prev  <= cur;
        steps <= steps + STEP_W'(1);
      end
      CMD_LG_UNLINK: begin
        res_addr <= cur;
        res_ok   <= 1'b1;
      end
      CMD_CARVE: begin
        res_addr <= ADDR_W'(carve + SIZE_W'(8));
        res_ok   <= 1'b1;
      end
      CMD_FR_LINK: begin
        res_addr <= '0;
        res_ok   <= 1'b1;
      end
      default: res_ok <= res_ok;
    endcase
    if (cmd == CMD_LOAD) hidx <= cls_in(rnd);
    else if (cmd == CMD_FR_Q) hidx <= CLASS_W'(q - SIZE_W'(1));
    if (cmd == CMD_LG_INIT) cur <= large_head;
    else if (cmd == CMD_LG_ADV) cur <= nx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CLASS_COUNT; k++) heads[k] <= '0;
      large_head <= '0;
      carve      <= '0;
    end else begin
      case (cmd)
        CMD_HEAD_POP: heads[hidx] <= nx_link;
        CMD_RF_END: begin
          heads[hidx] <= ADDR_W'(carve + SIZE_W'(8));
          carve       <= p;
        end
        CMD_CARVE: carve <= SIZE_W'(carve + SIZE_W'(real_sz));
        CMD_LG_UNLINK: begin
          if (prev == '0) large_head <= nx;
        end
        CMD_FR_LINK: begin
          if (fr_small) heads[hidx] <= faddr;
          else          large_head  <= faddr;
        end
        default: carve <= carve;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      out_addr <= res_addr;
      out_ok   <= res_ok;
    end
  end

endmodule

// ===== hw/rtl/segregated_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_unit
// Allocate/free engine over a 64 KiB pool with per-class and large free lists.
// ----------------------------------------------------------------------------
// One item is handled at a time; each gives one result beat. A class refill
// carves chunk by chunk, with one header and one link write per chunk on the
// single pool write port. A large allocate walks the large list node by node
// (link read, header read, compare) and carves from the pool end if no node
// matches. The result register lets the next item be taken while the
// previous result is still waiting on the output.
module segregated_free_list_allocator_unit
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size[15:0], free_addr[31:16]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_addr[15:0]
  output logic        m_tuser,   // success
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SIZE_W-1:0] pool_bytes;
  logic [RC_W-1:0]   refill_count;
  logic [SIZE_W-1:0] pool_end;
  status_t           status;
  cmd_t              cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes   <= SIZE_W'(65536);
      refill_count <= RC_W'(20);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_REFILL_COUNT[2]) refill_count <= pwdata[RC_W-1:0];
      else                                 pool_bytes   <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POOL_BYTES[2]) ? 32'(pool_bytes) : 32'(refill_count);

  assign pool_end = (pool_bytes < SIZE_W'(POOL_MAX_BYTES)) ? pool_bytes :
                    SIZE_W'(POOL_MAX_BYTES);

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sfla_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_opcode    (s_tuser),
    .in_size      (s_tdata[15:0]),
    .in_free_addr (s_tdata[31:16]),
    .pool_end     (pool_end),
    .refill_count (refill_count),
    .out_ready    (m_tready),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_addr     (m_tdata),
    .out_ok       (m_tuser)
  );

endmodule

// ===== bench/segregated_free_list_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_unit_tb
// Checks every allocate and free result of the allocator against a local
// model of the pool, the size-class lists, the large list and the carve
// pointer. A short directed table comes first, then random phases under
// several register settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_unit_tb;
  import sfla_pkg::*;

  localparam int LIMIT = 2000000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // request_size[15:0], free_addr[31:16]
  logic        s_tuser;   // opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // result_addr[15:0]
  logic        m_tuser;   // success
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  segregated_free_list_allocator_unit dut (.*);

  always #4 clk = ~clk;

  typedef struct {
    logic [15:0] addr;
    logic        ok;
  } alloc_result_t;

  typedef struct {
    logic        op;
    int unsigned size;
    int unsigned faddr;
    int          slot;
    logic        typed;
    logic [15:0] exp_addr;
    logic        exp_ok;
  } row_t;

  alloc_result_t result_q[$];
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  int unsigned   send_pct = 0;
  int unsigned   recv_pct = 0;

  logic [63:0]  pool_mem [POOL_WORDS];
  int unsigned  class_head [CLASS_COUNT];
  int unsigned  large_top;
  int unsigned  carve_at;
  int unsigned  pool_end_reg;
  int unsigned  refill_reg;

  int unsigned  live_q[$];
  int unsigned  freed_small_q[$];
  int unsigned  slots[4];
  int unsigned  large_sizes[5] = '{136, 200, 264, 520, 1024};

  function automatic logic body_ok(longint unsigned a);
    return a >= 8 && a < POOL_MAX_BYTES && a[2:0] == 3'd0;
  endfunction

  function automatic logic [63:0] mem_rd(int unsigned a);
    if (a % 8 != 0 || a >= POOL_MAX_BYTES) return 64'd0;
    return pool_mem[a >> 3];
  endfunction

  function automatic void mem_wr(int unsigned a, logic [63:0] v);
    if (a % 8 != 0 || a >= POOL_MAX_BYTES) return;
    pool_mem[a >> 3] = v;
  endfunction

  function automatic int unsigned next_of(int unsigned a);
    logic [63:0] v;
    v = mem_rd(a);
    return body_ok(v) ? int'(v) : 0;
  endfunction

  function automatic int unsigned room(int unsigned carve);
    int unsigned e;
    e = pool_end_reg < POOL_MAX_BYTES ? pool_end_reg : POOL_MAX_BYTES;
    return e > carve ? e - carve : 0;
  endfunction

  function automatic logic carve_class(int unsigned idx, int unsigned asz);
    int unsigned span, cnt, p;
    span = asz + 8;
    cnt = room(carve_at) / span;
    if (cnt > refill_reg) cnt = refill_reg;
    if (cnt == 0) return 1'b0;
    p = carve_at;
    for (int unsigned i = 0; i < cnt; i++) begin
      mem_wr(p, 64'(asz));
      mem_wr(p + 8, (i + 1 < cnt) ? 64'(p + span + 8) : 64'd0);
      p += span;
    end
    class_head[idx] = carve_at + 8;
    carve_at = p;
    return 1'b1;
  endfunction

  function automatic int unsigned take_chunk(int unsigned size);
    int unsigned asz, prev, c, nx, idx, r;
    if (size == 0) return 0;
    asz = ((size + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    if (size <= SMALL_MAX_BYTES) begin
      idx = asz / GRANULE_BYTES - 1;
      if (idx >= CLASS_COUNT) return 0;
      if (class_head[idx] == 0 && !carve_class(idx, asz)) return 0;
      r = class_head[idx];
      class_head[idx] = next_of(r);
      return r;
    end
    prev = 0;
    c = large_top;
    for (int unsigned s = 0; c != 0 && s < POOL_WORDS; s++) begin
      nx = next_of(c);
      if (mem_rd(c - 8) == 64'(asz)) begin
        if (prev == 0) large_top = nx;
        else mem_wr(prev, 64'(nx));
        return c;
      end
      prev = c;
      c = nx;
    end
    if (room(carve_at) >= asz + 8) begin
      r = carve_at + 8;
      mem_wr(carve_at, 64'(asz));
      carve_at += asz + 8;
      return r;
    end
    return 0;
  endfunction

  function automatic logic give_back(int unsigned a);
    logic [63:0] hsz;
    int unsigned q;
    if (!body_ok(a)) return 1'b0;
    hsz = mem_rd(a - 8);
    if (hsz <= SMALL_MAX_BYTES) begin
      q = int'(hsz) / GRANULE_BYTES;
      if (q == 0 || q > CLASS_COUNT) return 1'b0;
      mem_wr(a, 64'(class_head[q - 1]));
      class_head[q - 1] = a;
    end else begin
      mem_wr(a, 64'(large_top));
      large_top = a;
    end
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_item(logic op, int unsigned size,
                                                 int unsigned faddr);
    alloc_result_t res;
    int unsigned a;
    if (op == OP_ALLOC) begin
      a = take_chunk(size);
      res.addr = a[15:0];
      res.ok = a != 0;
      if (a != 0) live_q.push_back(a);
    end else begin
      res.addr = '0;
      res.ok = give_back(faddr);
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_item(logic op, int unsigned size, int unsigned faddr,
                           logic typed, logic [15:0] ea, logic eo,
                           output alloc_result_t res);
    alloc_result_t typed_res;
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    res = predict_item(op, size, faddr);
    typed_res.addr = ea;
    typed_res.ok = eo;
    result_q.push_back(typed ? typed_res : res);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {faddr[15:0], size[15:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == REG_POOL_BYTES) pool_end_reg = value & 32'h1FFFF;
    else refill_reg = value & 32'h7F;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item(logic wide_sizes);
    alloc_result_t res;
    int unsigned r, k, a, sz;
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 88 && live_q.size() == 0)) begin
      k = $urandom_range(0, 99);
      if (wide_sizes && k < 30) sz = $urandom_range(0, 65535);
      else if (k < 78) sz = $urandom_range(1, SMALL_MAX_BYTES);
      else if (k < 95) sz = large_sizes[$urandom_range(0, 4)] - $urandom_range(0, 7);
      else sz = 0;
      send_item(OP_ALLOC, sz, $urandom_range(0, 65535), 1'b0, '0, 1'b0, res);
    end else if (r < 88) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      if (mem_rd(a - 8) <= SMALL_MAX_BYTES) begin
        freed_small_q.push_back(a);
        if (freed_small_q.size() > 8) void'(freed_small_q.pop_front());
      end
      send_item(OP_FREE, $urandom_range(0, 65535), a, 1'b0, '0, 1'b0, res);
    end else if (r < 91 && freed_small_q.size() != 0) begin
      a = freed_small_q[$urandom_range(0, freed_small_q.size() - 1)];
      send_item(OP_FREE, $urandom_range(0, 65535), a, 1'b0, '0, 1'b0, res);
    end else begin
      k = $urandom_range(0, 3);
      case (k)
        0: a = 0;
        1: a = $urandom_range(1, 7);
        2: a = ($urandom_range(1, 8191) << 3) | $urandom_range(1, 7);
        default: a = $urandom_range(0, 65535) | 1;
      endcase
      send_item(OP_FREE, $urandom_range(0, 65535), a, 1'b0, '0, 1'b0, res);
    end
  endtask

  row_t dir_rows[$] = '{
    '{OP_ALLOC, 0,     0,     -1, 1'b1, 16'd0,  1'b0},
    '{OP_FREE,  5,     0,     -1, 1'b1, 16'd0,  1'b0},
    '{OP_FREE,  0,     5,     -1, 1'b1, 16'd0,  1'b0},
    '{OP_FREE,  0,     12,    -1, 1'b1, 16'd0,  1'b0},
    '{OP_ALLOC, 1,     0,     0,  1'b1, 16'd8,  1'b1},
    '{OP_ALLOC, 8,     0,     -1, 1'b1, 16'd24, 1'b1},
    '{OP_ALLOC, 16,    0,     1,  1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 128,   0,     -1, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 129,   0,     2,  1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 300,   0,     3,  1'b0, 16'd0,  1'b0},
    '{OP_FREE,  0,     0,     2,  1'b0, 16'd0,  1'b0},
    '{OP_FREE,  0,     0,     3,  1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 136,   0,     -1, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 300,   0,     -1, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 65535, 0,     -1, 1'b1, 16'd0,  1'b0},
    '{OP_FREE,  65535, 65535, -1, 1'b1, 16'd0,  1'b0},
    '{OP_FREE,  0,     0,     0,  1'b0, 16'd0,  1'b0},
    '{OP_FREE,  0,     0,     1,  1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 1,     0,     -1, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 120,   0,     -1, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 65535, 0,     -1, 1'b1, 16'd0,  1'b0}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    m_tready <= (recv_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        report("unexpected beat addr", m_tdata, -1);
      end else begin
        e = result_q.pop_front();
        if (m_tdata !== e.addr) report("result_addr", m_tdata, e.addr);
        if (m_tuser !== e.ok) report("success", m_tuser, e.ok);
      end
    end
  end

  initial begin
    alloc_result_t res;
    int unsigned a;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    m_tready <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    foreach (pool_mem[i]) pool_mem[i] = 64'd0;
    foreach (class_head[i]) class_head[i] = 0;
    large_top = 0;
    carve_at = 0;
    pool_end_reg = 65536;
    refill_reg = 20;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      a = dir_rows[i].faddr;
      if (dir_rows[i].op == OP_FREE && dir_rows[i].slot >= 0) a = slots[dir_rows[i].slot];
      send_item(dir_rows[i].op, dir_rows[i].size, a, dir_rows[i].typed,
                dir_rows[i].exp_addr, dir_rows[i].exp_ok, res);
      if (dir_rows[i].op == OP_ALLOC && dir_rows[i].slot >= 0) slots[dir_rows[i].slot] = res.addr;
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin apb_write(REG_POOL_BYTES, 65536); apb_write(REG_REFILL_COUNT, 20); end
        1: apb_write(REG_REFILL_COUNT, 64);
        2: apb_write(REG_REFILL_COUNT, 1);
        3: begin
          apb_write(REG_POOL_BYTES, carve_at + $urandom_range(16, 3000));
          apb_write(REG_REFILL_COUNT, 5);
        end
        4: apb_write(REG_POOL_BYTES, 16);
        5: begin
          apb_write(REG_POOL_BYTES, 65536);
          apb_write(REG_REFILL_COUNT, $urandom_range(1, 64));
        end
        6: begin
          apb_write(REG_POOL_BYTES, carve_at + 2000);
          apb_write(REG_REFILL_COUNT, 64);
        end
        default: begin apb_write(REG_POOL_BYTES, 65536); apb_write(REG_REFILL_COUNT, 20); end
      endcase
      case (ph % 4)
        0: begin send_pct = 0; recv_pct = 0; end
        1: begin send_pct = 83; recv_pct = 0; end
        2: begin send_pct = 0; recv_pct = 83; end
        default: begin send_pct = 10; recv_pct = 10; end
      endcase
      repeat (190) random_item(ph == 4);
      drain();
    end

    send_pct = 0;
    recv_pct = 0;
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfla_pkg.sv
hw/rtl/sfla_ctrl.sv
hw/rtl/sfla_dp.sv
hw/rtl/segregated_free_list_allocator_unit.sv
bench/segregated_free_list_allocator_unit_tb.sv
